// ===== hw/rtl/one_wire_bus_master_defines.svh =====
// Assertion macros for the 1-Wire bus master
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// same-cycle implication
`define OWB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OWB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/owb_pkg.sv =====
// Shared types and constants for the 1-Wire bus master
package owb_pkg;

	localparam int NUM_REGS = 8;
	localparam int REG_W    = 12;
	localparam int IDX_W    = 3;

	typedef logic [1:0] owb_action_t;
	localparam owb_action_t ACT_NONE  = 2'd0;
	localparam owb_action_t ACT_RESET = 2'd1;
	localparam owb_action_t ACT_WRITE = 2'd2;
	localparam owb_action_t ACT_READ  = 2'd3;

	localparam logic [IDX_W-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRES_WAIT    = 3'd1;
	localparam logic [IDX_W-1:0] REG_WRITE_LOW    = 3'd2;
	localparam logic [IDX_W-1:0] REG_WRITE_HOLD   = 3'd3;
	localparam logic [IDX_W-1:0] REG_RECOVERY     = 3'd4;
	localparam logic [IDX_W-1:0] REG_READ_LOW     = 3'd5;
	localparam logic [IDX_W-1:0] REG_READ_SAMPLE  = 3'd6;
	localparam logic [IDX_W-1:0] REG_READ_TAIL    = 3'd7;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] owb_cfg_t;

	localparam owb_cfg_t CFG_RESET = {
		12'd50, 12'd8, 12'd2, 12'd20, 12'd50, 12'd10, 12'd240, 12'd480
	};

	typedef struct packed {
		owb_action_t action;
		logic [7:0]  write_data;
		logic        line_level;
	} owb_item_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_byte;
		logic       command_ignored;
	} owb_res_t;

endpackage

// ===== hw/rtl/owb_ifs.sv =====
// Handshake interfaces for the command and result channels

interface owb_req_if;
	import owb_pkg::*;
	logic        valid;
	logic        ready;
	owb_action_t action;
	logic [7:0]  write_data;
	logic        line_level;

	modport source (output valid, output action, output write_data, output line_level,
		input ready);
	modport sink (input valid, input action, input write_data, input line_level,
		output ready);
endinterface

interface owb_rsp_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] read_byte;
	logic       command_ignored;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output presence, output read_byte, output command_ignored, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input presence, input read_byte, input command_ignored, output ready);
endinterface

// ===== hw/rtl/owb_cfg_regs.sv =====
// Timing register bank written through the configuration port
module owb_cfg_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [owb_pkg::IDX_W-1:0] index,
	input  logic [owb_pkg::REG_W-1:0] data,
	output owb_pkg::owb_cfg_t       regs
);
	import owb_pkg::*;

	owb_cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (wr_en) begin
			regs_q[index] <= data;
		end
	end

	assign regs = regs_q;
endmodule

// ===== hw/rtl/owb_engine.sv =====
// Phase machine, tick counter, bit index and shift register of the bus master
module owb_engine #(
	parameter int BITS_PER_TRANSFER = 8,
	parameter int TICK_COUNT_WIDTH  = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  owb_pkg::owb_item_t item,
	input  owb_pkg::owb_cfg_t  regs,
	output owb_pkg::owb_res_t  res
);
	import owb_pkg::*;

	localparam int LW = (TICK_COUNT_WIDTH + 1 > REG_W + 1) ? TICK_COUNT_WIDTH + 1 : REG_W + 1;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_WR_LOW   = 4'd3,
		PH_WR_HOLD  = 4'd4,
		PH_WR_REC   = 4'd5,
		PH_RD_LOW   = 4'd6,
		PH_RD_WAIT  = 4'd7,
		PH_RD_TAIL  = 4'd8
	} phase_t;

	phase_t                      phase_q, cur, phase_d;
	logic [TICK_COUNT_WIDTH-1:0] tick_q, tick, tick_d;
	logic [2:0]                  bidx_q, bidx, bidx_d;
	logic [7:0]                  shift_q, shift, shift_d;
	logic [3:0]                  sel_code;
	logic [REG_W-1:0]            len;
	logic                        last;
	logic                        final_bit;

	always_comb begin
		res = '0;
		res.command_ignored = (phase_q != PH_IDLE) && (item.action != ACT_NONE);
		cur   = phase_q;
		tick  = tick_q;
		bidx  = bidx_q;
		shift = shift_q;
		if ((phase_q == PH_IDLE) && (item.action != ACT_NONE)) begin
			tick  = '0;
			bidx  = '0;
			shift = (item.action == ACT_WRITE) ? item.write_data : 8'd0;
			unique case (item.action)
				ACT_RESET: cur = PH_RST_LOW;
				ACT_WRITE: cur = PH_WR_LOW;
				default:   cur = PH_RD_LOW;
			endcase
		end

		sel_code  = cur - 4'd1;
		len       = regs[sel_code[2:0]];
		last      = ((LW'(tick) + LW'(1)) >= LW'(len)) || (&tick);
		final_bit = ({1'b0, bidx} + 4'd1) >= 4'(BITS_PER_TRANSFER);

		phase_d = cur;
		tick_d  = tick;
		bidx_d  = bidx;
		shift_d = shift;

		if (cur != PH_IDLE) begin
			unique case (cur)
				PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: res.drive_low = 1'b1;
				PH_WR_HOLD: res.drive_low = ~shift[0];
				default:    res.drive_low = 1'b0;
			endcase
			tick_d = tick + 1'b1;
			if (last) begin
				tick_d = '0;
				unique case (cur)
					PH_RST_LOW: phase_d = PH_RST_WAIT;
					PH_RST_WAIT: begin
						res.presence = ~item.line_level;
						res.done_res = 1'b1;
						phase_d      = PH_IDLE;
						bidx_d       = '0;
					end
					PH_WR_LOW:  phase_d = PH_WR_HOLD;
					PH_WR_HOLD: phase_d = PH_WR_REC;
					PH_WR_REC: begin
						shift_d = {1'b0, shift[7:1]};
						if (final_bit) begin
							res.done_res = 1'b1;
							phase_d      = PH_IDLE;
							bidx_d       = '0;
						end else begin
							bidx_d  = bidx + 3'd1;
							phase_d = PH_WR_LOW;
						end
					end
					PH_RD_LOW: phase_d = PH_RD_WAIT;
					PH_RD_WAIT: begin
						if (item.line_level)
							shift_d[bidx] = 1'b1;
						phase_d = PH_RD_TAIL;
					end
					PH_RD_TAIL: begin
						if (final_bit) begin
							res.read_byte = shift;
							res.done_res  = 1'b1;
							phase_d       = PH_IDLE;
							bidx_d        = '0;
						end else begin
							bidx_d  = bidx + 3'd1;
							phase_d = PH_RD_LOW;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
		res.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bidx_q  <= '0;
			shift_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bidx_q  <= bidx_d;
			shift_q <= shift_d;
		end
	end
endmodule

// ===== hw/rtl/one_wire_bus_master.sv =====
// 1-Wire bus master top level: item register, engine, result register, timing registers
// An accepted item is held in the item register; its result is registered in the result register.
// One item per cycle unless rsp stalls; tick compare and phase update are combinational.
// Back-pressure on the result channel holds one item in the input register, then stalls req.
// Reset (arst_n low, asynchronous) idles the phase machine, empties both registers
// and loads the timing registers with their default values.
`include "one_wire_bus_master_defines.svh"

module one_wire_bus_master #(
	parameter int BITS_PER_TRANSFER = 8,
	parameter int TICK_COUNT_WIDTH  = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	owb_req_if.sink                   req,
	owb_rsp_if.source                 rsp,
	input  logic                      cfg_wr_en,
	input  logic [owb_pkg::IDX_W-1:0] cfg_index,
	input  logic [owb_pkg::REG_W-1:0] cfg_data
);
	import owb_pkg::*;

	owb_cfg_t  regs;
	owb_item_t item_s1;
	logic      valid_s1;
	owb_res_t  res;
	owb_res_t  res_q;
	logic      res_valid_q;
	logic      advance;

	assign advance   = valid_s1 && (!res_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	owb_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.regs   (regs)
	);

	owb_engine #(
		.BITS_PER_TRANSFER (BITS_PER_TRANSFER),
		.TICK_COUNT_WIDTH  (TICK_COUNT_WIDTH)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.regs    (regs),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (advance)
				res_valid_q <= 1'b1;
			else if (rsp.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.action     <= req.action;
			item_s1.write_data <= req.write_data;
			item_s1.line_level <= req.line_level;
		end
		if (advance)
			res_q <= res;
	end

	assign rsp.valid           = res_valid_q;
	assign rsp.drive_low       = res_q.drive_low;
	assign rsp.busy_res        = res_q.busy_res;
	assign rsp.done_res        = res_q.done_res;
	assign rsp.presence        = res_q.presence;
	assign rsp.read_byte       = res_q.read_byte;
	assign rsp.command_ignored = res_q.command_ignored;

	`OWB_ASSERT_NOW(a_done_not_busy, res_valid_q && res_q.done_res, !res_q.busy_res, "done while busy")
	`OWB_ASSERT_NOW(a_data_with_done, res_valid_q && (res_q.presence || res_q.read_byte != 8'd0), res_q.done_res, "presence or byte without done")
	`OWB_ASSERT_NEXT(a_held_item_kept, valid_s1 && !advance, valid_s1, "stalled item lost")
endmodule

// ===== dv/tb_one_wire_bus_master.sv =====
// Testbench for one_wire_bus_master: tick-by-tick bus prediction, random stalls, timing sweeps
module tb_one_wire_bus_master;
	import owb_pkg::*;

	localparam int XFER_BITS = 8;

	typedef enum logic [3:0] {
		B_IDLE, B_RST_LOW, B_RST_WAIT, B_WR_LOW, B_WR_HOLD, B_WR_REC,
		B_RD_LOW, B_RD_WAIT, B_RD_TAIL
	} bus_phase_t;

	localparam int LINE_RANDOM = 0;
	localparam int LINE_HIGH   = 1;
	localparam int LINE_LOW    = 2;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;

	owb_req_if req_ch();
	owb_rsp_if rsp_ch();

	one_wire_bus_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted bus state
	logic [REG_W-1:0] timing [NUM_REGS];
	bus_phase_t bus_ph;
	logic [11:0] slot_tick;
	logic [2:0]  bit_pos;
	logic [7:0]  shift_reg;

	owb_res_t bus_results_due [$];
	int fails = 0;
	int ticks_sent = 0;
	int tx_gap_max = 0;
	int rx_gap_max = 0;
	int rx_hold = 0;

	function automatic logic [12:0] slot_len(bus_phase_t p);
		logic [12:0] n;
		n = {1'b0, timing[int'(p) - 1]};
		if (n == 13'd0)
			n = 13'd1;
		return n;
	endfunction

	function automatic owb_res_t bus_tick_response(owb_item_t it);
		owb_res_t r;
		logic last;
		logic finish;
		r = '0;
		finish = 1'b0;
		if (bus_ph == B_IDLE) begin
			if (it.action != ACT_NONE) begin
				slot_tick = '0;
				bit_pos = '0;
				shift_reg = (it.action == ACT_WRITE) ? it.write_data : 8'h00;
				case (it.action)
					ACT_RESET: bus_ph = B_RST_LOW;
					ACT_WRITE: bus_ph = B_WR_LOW;
					default:   bus_ph = B_RD_LOW;
				endcase
			end
		end else if (it.action != ACT_NONE) begin
			r.command_ignored = 1'b1;
		end
		if (bus_ph != B_IDLE) begin
			last = ({1'b0, slot_tick} + 13'd1) >= slot_len(bus_ph);
			r.drive_low = (bus_ph == B_RST_LOW) || (bus_ph == B_WR_LOW) || (bus_ph == B_RD_LOW)
				|| (bus_ph == B_WR_HOLD && !shift_reg[0]);
			slot_tick = slot_tick + 12'd1;
			if (last) begin
				slot_tick = '0;
				case (bus_ph)
					B_RST_WAIT: begin
						r.presence = ~it.line_level;
						finish = 1'b1;
					end
					B_RD_WAIT: begin
						if (it.line_level)
							shift_reg[bit_pos] = 1'b1;
						bus_ph = B_RD_TAIL;
					end
					B_WR_REC, B_RD_TAIL: begin
						if (bus_ph == B_WR_REC)
							shift_reg = shift_reg >> 1;
						if (int'(bit_pos) + 1 >= XFER_BITS) begin
							if (bus_ph == B_RD_TAIL)
								r.read_byte = shift_reg;
							finish = 1'b1;
						end else begin
							bit_pos = bit_pos + 3'd1;
							bus_ph = (bus_ph == B_WR_REC) ? B_WR_LOW : B_RD_LOW;
						end
					end
					default: bus_ph = bus_phase_t'(bus_ph + 4'd1);
				endcase
				if (finish) begin
					bus_ph = B_IDLE;
					bit_pos = '0;
					r.done_res = 1'b1;
				end
			end
		end
		r.busy_res = (bus_ph != B_IDLE);
		return r;
	endfunction

	function automatic logic pick_line(int mode);
		if (mode == LINE_HIGH)
			return 1'b1;
		if (mode == LINE_LOW)
			return 1'b0;
		return 1'($urandom_range(1, 0));
	endfunction

	// called in a posedge step; leaves valid high after the item is taken
	task automatic send_tick(owb_item_t it);
		int gap;
		logic taken;
		gap = $urandom_range(tx_gap_max, 0);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= it.action;
		req_ch.write_data <= it.write_data;
		req_ch.line_level <= it.line_level;
		do begin
			@(negedge clk);
			taken = req_ch.ready;
			@(posedge clk);
		end while (!taken);
		bus_results_due.push_back(bus_tick_response(it));
		ticks_sent++;
	endtask

	// one command, then ticks until the bus goes idle; noise is the chance of a busy command
	task automatic run_op(owb_action_t act, logic [7:0] data, int line_mode, int noise_pct);
		owb_item_t it;
		it.action = act;
		it.write_data = data;
		it.line_level = pick_line(line_mode);
		send_tick(it);
		while (bus_ph != B_IDLE) begin
			it.action = ($urandom_range(99, 0) < noise_pct) ?
				owb_action_t'($urandom_range(3, 1)) : ACT_NONE;
			it.write_data = 8'($urandom);
			it.line_level = pick_line(line_mode);
			send_tick(it);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (bus_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		timing[idx] = val;
		@(posedge clk);
	endtask

	task automatic load_timing(logic [REG_W-1:0] rl, logic [REG_W-1:0] pw,
		logic [REG_W-1:0] wl, logic [REG_W-1:0] wh, logic [REG_W-1:0] rc,
		logic [REG_W-1:0] dl, logic [REG_W-1:0] ds, logic [REG_W-1:0] dt);
		cfg_write(REG_RESET_LOW, rl);
		cfg_write(REG_PRES_WAIT, pw);
		cfg_write(REG_WRITE_LOW, wl);
		cfg_write(REG_WRITE_HOLD, wh);
		cfg_write(REG_RECOVERY, rc);
		cfg_write(REG_READ_LOW, dl);
		cfg_write(REG_READ_SAMPLE, ds);
		cfg_write(REG_READ_TAIL, dt);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// read slot timing straight out of reset
	task automatic test_reset_values();
		tx_gap_max = 3;
		rx_gap_max = 3;
		run_op(ACT_READ, 8'h00, LINE_RANDOM, 0);
		drain();
	endtask

	task automatic test_shortest_slots();
		load_timing(12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
		tx_gap_max = 11;
		rx_gap_max = 11;
		// a command on every busy tick, the done tick included
		run_op(ACT_RESET, 8'hFF, LINE_RANDOM, 100);
		run_op(ACT_RESET, 8'h00, LINE_LOW, 0);
		run_op(ACT_RESET, 8'h00, LINE_HIGH, 0);
		run_op(ACT_NONE, 8'hFF, LINE_HIGH, 0);
		run_op(ACT_WRITE, 8'h00, LINE_RANDOM, 0);
		run_op(ACT_WRITE, 8'hFF, LINE_RANDOM, 0);
		run_op(ACT_READ, 8'h00, LINE_HIGH, 0);
		run_op(ACT_READ, 8'hFF, LINE_LOW, 0);
		drain();
	endtask

	task automatic test_backpressure();
		load_timing(12'd3, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2);
		tx_gap_max = 0;
		rx_gap_max = 0;
		rx_hold = 120;
		run_op(ACT_READ, 8'h00, LINE_RANDOM, 5);
		drain();
	endtask

	task automatic test_random_traffic();
		int stop_at;
		for (int s = 0; s < 5; s++) begin
			load_timing(12'($urandom_range(8, 1)), 12'($urandom_range(8, 1)),
				12'($urandom_range(3, 1)), 12'($urandom_range(3, 1)),
				12'($urandom_range(3, 1)), 12'($urandom_range(3, 1)),
				12'($urandom_range(3, 1)), 12'($urandom_range(3, 1)));
			tx_gap_max = (s == 0) ? 0 : (s == 1) ? 11 : $urandom_range(11, 0);
			rx_gap_max = (s == 0) ? 0 : (s == 2) ? 11 : $urandom_range(11, 0);
			stop_at = ticks_sent + 20;
			while (ticks_sent < stop_at) begin
				if ($urandom_range(9, 0) == 0)
					run_op(ACT_NONE, 8'($urandom), LINE_RANDOM, 0);
				else
					run_op(owb_action_t'($urandom_range(3, 1)), 8'($urandom),
						($urandom_range(3, 0) == 0) ? $urandom_range(2, 1) : LINE_RANDOM, 5);
			end
			drain();
		end
	endtask

	task automatic cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(negedge clk) begin
		owb_res_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (bus_results_due.size() == 0) begin
				$error("result item with none expected");
				fails++;
			end else begin
				e = bus_results_due.pop_front();
				cmp_field("drive_low", e.drive_low, rsp_ch.drive_low);
				cmp_field("busy_res", e.busy_res, rsp_ch.busy_res);
				cmp_field("done_res", e.done_res, rsp_ch.done_res);
				cmp_field("presence", e.presence, rsp_ch.presence);
				cmp_field("read_byte", e.read_byte, rsp_ch.read_byte);
				cmp_field("command_ignored", e.command_ignored, rsp_ch.command_ignored);
			end
		end
	end

	// result side: random stalls per item, or one long hold when asked
	initial begin
		int n;
		logic got;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = $urandom_range(rx_gap_max, 0);
			end
			if (n > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				got = rsp_ch.valid;
				@(posedge clk);
			end while (!got);
		end
	end

	initial begin
		timing[REG_RESET_LOW]   = 12'd480;
		timing[REG_PRES_WAIT]   = 12'd240;
		timing[REG_WRITE_LOW]   = 12'd10;
		timing[REG_WRITE_HOLD]  = 12'd50;
		timing[REG_RECOVERY]    = 12'd20;
		timing[REG_READ_LOW]    = 12'd2;
		timing[REG_READ_SAMPLE] = 12'd8;
		timing[REG_READ_TAIL]   = 12'd50;
		bus_ph = B_IDLE;
		slot_tick = '0;
		bit_pos = '0;
		shift_reg = '0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_NONE;
		req_ch.write_data <= '0;
		req_ch.line_level <= 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_values();
		test_shortest_slots();
		test_backpressure();
		test_random_traffic();
		drain();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== one_wire_bus_master.f =====
+incdir+hw/rtl
hw/rtl/owb_pkg.sv
hw/rtl/owb_ifs.sv
hw/rtl/owb_cfg_regs.sv
hw/rtl/owb_engine.sv
hw/rtl/one_wire_bus_master.sv
dv/tb_one_wire_bus_master.sv
